// ===== rtl/core/rrbcm_pkg.sv =====
// shared types and codes for the round-robin block cache map
`timescale 1ns / 1ps

package rrbcm_pkg;

	localparam int DISK_BLOCK_W = 12;
	localparam int SLOT_FIELD_W = 4;
	localparam int CFG_W        = 5;
	localparam int MAX_RESULTS  = 16;

	localparam logic CMD_ACCESS = 1'b0;
	localparam logic CMD_FLUSH  = 1'b1;

	typedef struct packed {
		logic                    cmd;
		logic [DISK_BLOCK_W-1:0] disk_block;
	} req_t;

	typedef struct packed {
		logic [SLOT_FIELD_W-1:0] slot;
		logic                    hit;
		logic                    writeback;
		logic [DISK_BLOCK_W-1:0] writeback_block;
		logic                    fill;
		logic                    last;
	} result_t;

endpackage

// ===== rtl/core/round_robin_block_cache_map_top.sv =====
// round-robin block cache map: block-to-slot lookup, replacement and flush walk
`timescale 1ns / 1ps

// channel   | direction | handshake                        | payload
// ----------+-----------+----------------------------------+-------------------
// request   | in        | start high while busy low        | req (req_t)
// result    | out       | result_strobe, one cycle, no hold| result (result_t)
// config    | in        | cfg_valid and cfg_ready          | cfg_data (slots in use)
//
// sequence: a hit is accepted with the map read, then looked up; a miss likewise, with
//   an extra invalidate step when the victim held a block, since the one write port of
//   the location map must drop the old block separately. blocks counts below 4096 add a
//   reciprocal modulo step and a separate map read step. a flush is accepted, then reads
//   each slot up to the last occupied slot in use and writes back each occupied one, or
//   ends after one read step when no slot in use is occupied.
// reset: after arst_n rises the location map is swept, one entry a cycle, with busy
//   high until every entry is cleared; config writes are taken during the sweep.
// stalls: the receiver cannot stall; each result is held in an output register and is
//   flagged by result_strobe for exactly one cycle, so a new transaction may start while it shows.

module round_robin_block_cache_map_top
	import rrbcm_pkg::*;
#(
	parameter int NUM_SLOTS       = 16,
	parameter int NUM_DISK_BLOCKS = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  req_t             req,
	output logic             result_strobe,
	output result_t          result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data
);

	localparam int SLOT_W   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CNT_W    = SLOT_W + 1;
	localparam int BLK_W    = $clog2(NUM_DISK_BLOCKS);
	localparam int LOC_W    = SLOT_W + 1;
	localparam int N_MAX    = (NUM_SLOTS < MAX_RESULTS) ? NUM_SLOTS : MAX_RESULTS;
	localparam bit NEED_MOD = (NUM_DISK_BLOCKS < (1 << DISK_BLOCK_W));
	localparam int RECIP    = (1 << 24) / NUM_DISK_BLOCKS;
	localparam logic [16:0] NDB_C = 17'(NUM_DISK_BLOCKS);
	localparam logic [BLK_W-1:0] CLR_LAST = BLK_W'(NUM_DISK_BLOCKS - 1);

	// one-hot sequencer
	typedef enum logic [7:0] {
		ST_CLEAR = 8'b0000_0001,
		ST_IDLE  = 8'b0000_0010,
		ST_MOD   = 8'b0000_0100,
		ST_RD    = 8'b0000_1000,
		ST_LOOK  = 8'b0001_0000,
		ST_INVAL = 8'b0010_0000,
		ST_FL_RD = 8'b0100_0000,
		ST_FL_WR = 8'b1000_0000
	} state_t;

	state_t state_q;

	// location map: valid bit on top, slot below
	logic [LOC_W-1:0]  loc_mem [NUM_DISK_BLOCKS];
	logic [LOC_W-1:0]  loc_rd_q;
	// owner map: block number per slot; valid bits live in flops
	logic [BLK_W-1:0]  owner_mem [NUM_SLOTS];
	logic [BLK_W-1:0]  owner_rd_q;
	logic [NUM_SLOTS-1:0] owner_valid_q;

	logic [CFG_W-1:0]  cfg_q;
	logic [SLOT_W-1:0] ptr_q;
	logic [SLOT_W-1:0] victim_q;
	logic [BLK_W-1:0]  blk_q;
	logic [BLK_W-1:0]  old_q;
	logic [BLK_W-1:0]  clr_addr_q;
	logic [CNT_W-1:0]  fl_idx_q;
	logic [DISK_BLOCK_W-1:0] x_q;
	logic [DISK_BLOCK_W-1:0] quot_q;
	result_t           result_q;
	logic              strobe_q;

	logic              accept;
	logic [CFG_W-1:0]  n5;
	logic [CNT_W-1:0]  n_eff;
	logic [SLOT_W-1:0] victim;
	logic [CNT_W-1:0]  ptr_next_ext;
	logic [SLOT_W-1:0] ptr_next;
	logic [BLK_W-1:0]  blk_in;
	logic [35:0]       prod;
	logic [28:0]       qd;
	logic [DISK_BLOCK_W-1:0] r_raw;
	logic [DISK_BLOCK_W-1:0] r_fix;
	logic              more_from;
	logic              more_after;
	logic              loc_we;
	logic [BLK_W-1:0]  loc_wa;
	logic [LOC_W-1:0]  loc_wd;
	logic              loc_re;
	logic [BLK_W-1:0]  loc_ra;
	logic              own_re;
	logic [SLOT_W-1:0] own_ra;
	logic              miss;

	assign accept        = start && (state_q == ST_IDLE);
	assign busy          = (state_q != ST_IDLE);
	assign cfg_ready     = 1'b1;
	assign result        = result_q;
	assign result_strobe = strobe_q;

	// effective slot count: zero acts as one, saturate at the slot and result limits
	always_comb begin
		if (cfg_q == '0) begin
			n5 = CFG_W'(1);
		end else if (cfg_q > CFG_W'(N_MAX)) begin
			n5 = CFG_W'(N_MAX);
		end else begin
			n5 = cfg_q;
		end
		n_eff = CNT_W'(n5);
	end

	// pointer wraps before use and after advance
	assign victim       = ({1'b0, ptr_q} >= n_eff) ? '0 : ptr_q;
	assign ptr_next_ext = {1'b0, victim_q} + CNT_W'(1);
	assign ptr_next     = (ptr_next_ext >= n_eff) ? '0 : ptr_next_ext[SLOT_W-1:0];

	// block reduction: reciprocal estimate, then one correcting subtract
	assign blk_in = BLK_W'(req.disk_block);
	assign prod   = 36'(req.disk_block) * 36'(RECIP);
	assign qd     = 29'(quot_q) * 29'(NUM_DISK_BLOCKS);
	assign r_raw  = x_q - qd[DISK_BLOCK_W-1:0];
	assign r_fix  = (17'(r_raw) >= NDB_C) ? (r_raw - NDB_C[DISK_BLOCK_W-1:0]) : r_raw;

	// occupied slots left in the flush window
	always_comb begin
		more_from  = 1'b0;
		more_after = 1'b0;
		for (int j = 0; j < NUM_SLOTS; j++) begin
			if (owner_valid_q[j] && (CNT_W'(j) < n_eff)) begin
				if (CNT_W'(j) >= fl_idx_q) more_from = 1'b1;
				if (CNT_W'(j) > fl_idx_q) more_after = 1'b1;
			end
		end
	end

	assign miss = (state_q == ST_LOOK) && !loc_rd_q[SLOT_W];

	// location map port selection
	always_comb begin
		loc_we = 1'b0;
		loc_wa = clr_addr_q;
		loc_wd = '0;
		unique case (state_q)
			ST_CLEAR: begin
				loc_we = 1'b1;
			end
			ST_LOOK: begin
				loc_we = miss;
				loc_wa = blk_q;
				loc_wd = {1'b1, victim_q};
			end
			ST_INVAL: begin
				loc_we = 1'b1;
				loc_wa = old_q;
			end
			ST_FL_WR: begin
				loc_we = 1'b1;
				loc_wa = owner_rd_q;
			end
			default: begin
				loc_we = 1'b0;
			end
		endcase
	end

	assign loc_re = (accept && !NEED_MOD && (req.cmd == CMD_ACCESS)) || (state_q == ST_RD);
	assign loc_ra = (state_q == ST_IDLE) ? blk_in : blk_q;
	assign own_re = loc_re || (state_q == ST_FL_RD);
	assign own_ra = (state_q == ST_FL_RD) ? fl_idx_q[SLOT_W-1:0] : victim;

	always_ff @(posedge clk) begin
		if (loc_we) loc_mem[loc_wa] <= loc_wd;
		if (loc_re) loc_rd_q <= loc_mem[loc_ra];
	end

	always_ff @(posedge clk) begin
		if (miss) owner_mem[victim_q] <= blk_q;
		if (own_re) owner_rd_q <= owner_mem[own_ra];
	end

	// config register, taken in any state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_W'(MAX_RESULTS);
		end else if (cfg_valid && cfg_ready) begin
			cfg_q <= cfg_data;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q    <= req.disk_block;
			quot_q <= prod[35:24];
			blk_q  <= blk_in;
		end
		if (state_q == ST_MOD) blk_q <= BLK_W'(r_fix);
		if (own_re && (state_q != ST_FL_RD)) victim_q <= victim;
		if (state_q == ST_LOOK) old_q <= owner_rd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			clr_addr_q    <= '0;
			ptr_q         <= '0;
			fl_idx_q      <= '0;
			owner_valid_q <= '0;
			strobe_q      <= 1'b0;
			result_q      <= '0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + BLK_W'(1);
					if (clr_addr_q == CLR_LAST) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept) begin
						if (req.cmd == CMD_FLUSH) begin
							fl_idx_q <= '0;
							state_q  <= ST_FL_RD;
						end else if (NEED_MOD) begin
							state_q <= ST_MOD;
						end else begin
							state_q <= ST_LOOK;
						end
					end
				end
				ST_MOD: begin
					state_q <= ST_RD;
				end
				ST_RD: begin
					state_q <= ST_LOOK;
				end
				ST_LOOK: begin
					strobe_q             <= 1'b1;
					result_q.last        <= 1'b1;
					if (loc_rd_q[SLOT_W]) begin
						// hit: report the mapped slot
						result_q.slot            <= SLOT_FIELD_W'(loc_rd_q[SLOT_W-1:0]);
						result_q.hit             <= 1'b1;
						result_q.writeback       <= 1'b0;
						result_q.writeback_block <= '0;
						result_q.fill            <= 1'b0;
						state_q                  <= ST_IDLE;
					end else begin
						// miss: take the victim, write back its old block if any
						result_q.slot      <= SLOT_FIELD_W'(victim_q);
						result_q.hit       <= 1'b0;
						result_q.fill      <= 1'b1;
						result_q.writeback <= owner_valid_q[victim_q];
						result_q.writeback_block <= owner_valid_q[victim_q] ?
							DISK_BLOCK_W'(owner_rd_q) : '0;
						owner_valid_q[victim_q] <= 1'b1;
						ptr_q   <= ptr_next;
						state_q <= owner_valid_q[victim_q] ? ST_INVAL : ST_IDLE;
					end
				end
				ST_INVAL: begin
					state_q <= ST_IDLE;
				end
				ST_FL_RD: begin
					if (!more_from) begin
						state_q <= ST_IDLE;
					end else if (owner_valid_q[fl_idx_q[SLOT_W-1:0]]) begin
						state_q <= ST_FL_WR;
					end else begin
						fl_idx_q <= fl_idx_q + CNT_W'(1);
					end
				end
				ST_FL_WR: begin
					strobe_q                 <= 1'b1;
					result_q.slot            <= SLOT_FIELD_W'(fl_idx_q[SLOT_W-1:0]);
					result_q.hit             <= 1'b0;
					result_q.writeback       <= 1'b1;
					result_q.writeback_block <= DISK_BLOCK_W'(owner_rd_q);
					result_q.fill            <= 1'b0;
					result_q.last            <= !more_after;
					owner_valid_q[fl_idx_q[SLOT_W-1:0]] <= 1'b0;
					fl_idx_q <= fl_idx_q + CNT_W'(1);
					state_q  <= more_after ? ST_FL_RD : ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/rrbcm_checker.sv =====
// port-level checks for the round-robin block cache map, bound to the top level
`timescale 1ns / 1ps

module rrbcm_checker
	import rrbcm_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             result_strobe,
	input result_t          result
);

	// an accepted transaction keeps the block busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy low right after accepting a transaction");

	// results come only out of work that was under way
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> $past(busy))
		else $error("result without preceding busy cycle");

	// a hit neither fills nor writes back and ends its transaction
	a_hit_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && result.hit) |-> (!result.fill && !result.writeback && result.last))
		else $error("malformed hit result");

	// no write-back means a zero block number
	a_wb_block: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && !result.writeback) |-> (result.writeback_block == '0))
		else $error("write-back block set without write-back");

	// a flush result that is not the last keeps the block busy
	a_flush_more: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && !result.last) |-> busy)
		else $error("block idle while flush results remain");

endmodule

bind round_robin_block_cache_map_top rrbcm_checker u_rrbcm_checker (.*);
